/* sv/prq_pkg.sv */
`default_nettype none

package prq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;
    localparam logic [1:0] CMD_REMOVE = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [1:0] OP_HOLD      = 2'd0;
    localparam logic [1:0] OP_WRITE     = 2'd1;
    localparam logic [1:0] OP_SHIFT_IN  = 2'd2;
    localparam logic [1:0] OP_SHIFT_OUT = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] proc_id;
        logic [7:0]  proc_priority;
        logic [15:0] run_time;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] removed_id;
        logic [4:0]  entry_count;
    } res_item_t;

    typedef struct packed {
        logic [15:0] proc_id;
        logic [7:0]  proc_priority;
        logic [15:0] run_time;
    } slot_t;

    typedef struct packed {
        logic [1:0] op;
        slot_t      slot;
    } cell_ctl_t;

    typedef struct packed {
        logic        tok;
        logic        have;
        logic [15:0] run_time;
        logic [15:0] proc_id;
    } scan_t;

endpackage

`default_nettype wire

/* sv/prq_cell.sv */
`default_nettype none

module prq_cell
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    parameter int CELL_IDX    = 0,
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_ctl_t        ctl,
    input  wire logic [IDX_W-1:0] ctl_idx,
    input  wire logic [CNT_W-1:0] occ,
    input  wire slot_t            prev_slot,
    input  wire slot_t            next_slot,
    output slot_t                 slot,
    input  wire scan_t            scan_in,
    input  wire logic [IDX_W-1:0] scan_idx_in,
    output scan_t                 scan_out,
    output logic [IDX_W-1:0]      scan_idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

    slot_t            slot_reg;
    slot_t            slot_next;
    scan_t            scan_reg;
    scan_t            scan_next;
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] scan_idx_next;
    logic             occupied;

    assign occupied = MY_CNT < occ;

    always_comb
    begin
        slot_next = slot_reg;
        case (ctl.op)
            OP_WRITE:
            begin
                if (ctl_idx == MY_IDX)
                begin
                    slot_next = ctl.slot;
                end
            end
            OP_SHIFT_IN:
            begin
                slot_next = prev_slot;
            end
            OP_SHIFT_OUT:
            begin
                if (MY_IDX >= ctl_idx)
                begin
                    slot_next = next_slot;
                end
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_comb
    begin
        scan_next     = scan_in;
        scan_idx_next = scan_idx_in;
        if (scan_in.tok && occupied && (!scan_in.have || (slot_reg.run_time > scan_in.run_time)))
        begin
            scan_next.have     = 1'b1;
            scan_next.run_time = slot_reg.run_time;
            scan_next.proc_id  = slot_reg.proc_id;
            scan_idx_next      = MY_IDX;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        scan_idx_reg <= scan_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    assign slot         = slot_reg;
    assign scan_out     = scan_reg;
    assign scan_idx_out = scan_idx_reg;

endmodule

`default_nettype wire

/* sv/process_queue_remove_longest.sv */
`default_nettype none

// Bounded queue of process records held in a row of QUEUE_DEPTH cells, head in cell 0.
// Append, insert at head and pop finish in the cycle they are accepted. Remove
// longest passes a search token down the cell row, one cell per cycle; when it
// leaves the last cell the queue closes the gap. Each result beat goes to an output
// register, or to one skid entry while the output beat still waits, so a command can
// be accepted while the previous result beat waits; commands are taken only while
// idle with the skid entry empty. Full inserts report status full; removals from an
// empty queue report status empty; removed_id is zero when nothing leaves.

module process_queue_remove_longest
    import prq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire cmd_item_t cmd_item,
    output logic           res_valid,
    input  wire logic      res_ready,
    output res_item_t      res_item
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;

    logic             out_valid_reg;
    res_item_t        out_reg;
    logic             skid_valid_reg;
    res_item_t        skid_reg;

    logic             cmd_fire;
    logic             full;
    logic             empty;
    logic             res_push;
    res_item_t        res_new;
    logic             res_pop;

    cell_ctl_t        ctl;
    logic [IDX_W-1:0] ctl_idx;
    scan_t            scan_start;

    slot_t            slots    [QUEUE_DEPTH];
    scan_t            scans    [QUEUE_DEPTH];
    logic [IDX_W-1:0] scan_idxs[QUEUE_DEPTH];

    scan_t            scan_last;
    logic [IDX_W-1:0] scan_last_idx;

    assign scan_last     = scans[QUEUE_DEPTH-1];
    assign scan_last_idx = scan_idxs[QUEUE_DEPTH-1];

    assign cmd_ready = (state_reg == S_IDLE) && !skid_valid_reg;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign full      = occ_reg == CNT_W'(QUEUE_DEPTH);
    assign empty     = occ_reg == '0;

    always_comb
    begin
        state_next             = state_reg;
        occ_next               = occ_reg;
        ctl.op                 = OP_HOLD;
        ctl.slot.proc_id       = cmd_item.proc_id;
        ctl.slot.proc_priority = cmd_item.proc_priority;
        ctl.slot.run_time      = cmd_item.run_time;
        ctl_idx                = occ_reg[IDX_W-1:0];
        scan_start             = '0;
        res_push               = 1'b0;
        res_new.status         = STATUS_OK;
        res_new.removed_id     = '0;

        if (cmd_fire)
        begin
            unique case (cmd_item.cmd) inside
                CMD_APPEND, CMD_INSERT:
                begin
                    res_push = 1'b1;
                    if (full)
                    begin
                        res_new.status = STATUS_FULL;
                    end
                    else
                    begin
                        ctl.op   = (cmd_item.cmd == CMD_APPEND) ? OP_WRITE : OP_SHIFT_IN;
                        occ_next = occ_reg + CNT_W'(1);
                    end
                end
                CMD_POP:
                begin
                    res_push = 1'b1;
                    if (empty)
                    begin
                        res_new.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        ctl.op             = OP_SHIFT_OUT;
                        ctl_idx            = '0;
                        res_new.removed_id = slots[0].proc_id;
                        occ_next           = occ_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    if (empty)
                    begin
                        res_push       = 1'b1;
                        res_new.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        scan_start.tok = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            endcase
        end
        else if ((state_reg == S_SCAN) && scan_last.tok)
        begin
            ctl.op             = OP_SHIFT_OUT;
            ctl_idx            = scan_last_idx;
            res_push           = 1'b1;
            res_new.removed_id = scan_last.proc_id;
            occ_next           = occ_reg - CNT_W'(1);
            state_next         = S_IDLE;
        end

        res_new.entry_count = 5'(occ_next);
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        slot_t            prev_w;
        slot_t            next_w;
        scan_t            scan_in_w;
        logic [IDX_W-1:0] scan_idx_in_w;

        if (g == 0)
        begin : g_head
            assign prev_w        = ctl.slot;
            assign scan_in_w     = scan_start;
            assign scan_idx_in_w = '0;
        end
        else
        begin : g_body
            assign prev_w        = slots[g-1];
            assign scan_in_w     = scans[g-1];
            assign scan_idx_in_w = scan_idxs[g-1];
        end

        if (g == QUEUE_DEPTH - 1)
        begin : g_tail
            assign next_w = slots[g];
        end
        else
        begin : g_inner
            assign next_w = slots[g+1];
        end

        prq_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .CELL_IDX    (g)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .ctl_idx      (ctl_idx),
            .occ          (occ_reg),
            .prev_slot    (prev_w),
            .next_slot    (next_w),
            .slot         (slots[g]),
            .scan_in      (scan_in_w),
            .scan_idx_in  (scan_idx_in_w),
            .scan_out     (scans[g]),
            .scan_idx_out (scan_idxs[g])
        );
    end

    assign res_pop = out_valid_reg && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            occ_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (!out_valid_reg || res_pop)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= res_push;
                end
                else
                begin
                    out_valid_reg <= res_push;
                end
            end
            else if (res_push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || res_pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg  <= skid_reg;
                skid_reg <= res_new;
            end
            else
            begin
                out_reg <= res_new;
            end
        end
        else if (res_push)
        begin
            skid_reg <= res_new;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output beat");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    a_scan_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_last.tok |-> (state_reg == S_SCAN))
        else $error("search token left the row outside a search");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && !full && ((cmd_item.cmd == CMD_APPEND) || (cmd_item.cmd == CMD_INSERT)))
        |=> (occ_reg == $past(occ_reg) + CNT_W'(1)))
        else $error("insert did not grow the queue");

    a_no_push_when_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !res_pop) |-> !res_push)
        else $error("result beat lost while output stage full");

endmodule

`default_nettype wire
